[hdl/ppft_pkg.sv]
package ppft_pkg;

    localparam int CORES            = 8;
    localparam int FILTER_ENTRIES   = 4096;  // power of two
    localparam int EPOCH            = 8192;
    localparam int LINE_OFFSET_BITS = 6;

    localparam int ADDR_W  = 48;
    localparam int CORE_W  = 4;
    localparam int NODE_W  = 6;
    localparam int DATA_W  = 32;
    localparam int ACC_W   = 10;
    localparam int POL_W   = 14;
    localparam int PROD_W  = ACC_W + DATA_W;
    localparam int IDX_W   = $clog2(FILTER_ENTRIES);
    localparam int ECNT_W  = $clog2(EPOCH);
    localparam int CFG_IDX_W = 2;

    localparam logic [POL_W-1:0]  POL_MAX    = '1;
    localparam logic [ECNT_W-1:0] EPOCH_LAST = ECNT_W'(EPOCH - 1);
    localparam logic [IDX_W-1:0]  IDX_LAST   = IDX_W'(FILTER_ENTRIES - 1);

    localparam logic [ACC_W-1:0]  ACC_LIMIT_RST  = 10'd150;
    localparam logic [POL_W-1:0]  POL_LIMIT_RST  = 14'd90;
    localparam logic [DATA_W-1:0] BWC_LIMIT_RST  = 32'd50000;
    localparam logic [DATA_W-1:0] BWNO_LIMIT_RST = 32'd75000;

    typedef enum logic [1:0] {
        CMD_MISS   = 2'd0,
        CMD_CLEAR  = 2'd1,
        CMD_SET    = 2'd2,
        CMD_DECIDE = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ACC_LIMIT  = 2'd0,
        REG_POL_LIMIT  = 2'd1,
        REG_BWC_LIMIT  = 2'd2,
        REG_BWNO_LIMIT = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        LVL_LOW  = 2'd0,
        LVL_MID  = 2'd1,
        LVL_HIGH = 2'd2
    } lvl_t;

    typedef struct packed {
        logic [ACC_W-1:0]  acc_limit;
        logic [POL_W-1:0]  pol_limit;
        logic [DATA_W-1:0] bwc_limit;
        logic [DATA_W-1:0] bwno_limit;
    } cfg_t;

    typedef struct packed {
        logic              valid;
        logic              mark;
        logic [NODE_W-1:0] owner;
    } entry_t;

    typedef entry_t [CORES-1:0] row_t;

    // line bits 0-11 xor line bits 12-23, reduced to the filter depth
    function automatic logic [IDX_W-1:0] filt_index(input logic [ADDR_W-1:0] address);
        logic [ADDR_W-1:0]   line;
        logic [IDX_W+11:0]   folded;
        begin
            line   = address >> LINE_OFFSET_BITS;
            folded = {{IDX_W{1'b0}}, line[11:0] ^ line[23:12]};
            return folded[IDX_W-1:0];
        end
    endfunction

endpackage

[hdl/prefetch_pollution_filter_throttle.sv]
// Results: a taken request passes ST_READ, then ST_RES, from which done is registered.
// A new request can be taken in ST_RES, before the last one's done; the pace is set by
// the read and write-back of one filter memory row holding the entries of all cores.
// Reset: control state and counters clear, limits take reset values, at once; the filter
// memory is then swept, one row a cycle, with busy high. Results cannot be stalled.
module prefetch_pollution_filter_throttle
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    command,
    input  logic [ppft_pkg::ADDR_W-1:0]   address,
    input  logic [ppft_pkg::CORE_W-1:0]   core,
    input  logic [ppft_pkg::NODE_W-1:0]   node_id,
    input  logic [ppft_pkg::DATA_W-1:0]   useful_count,
    input  logic [ppft_pkg::DATA_W-1:0]   issued_count,
    input  logic [ppft_pkg::DATA_W-1:0]   bw_consumed,
    input  logic [ppft_pkg::DATA_W-1:0]   bw_needed_others,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ppft_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ppft_pkg::DATA_W-1:0]   cfg_data,
    output logic                          done,
    output logic                          epoch_end,
    output logic                          decision_valid,
    output logic [1:0]                    level,
    output logic [ppft_pkg::POL_W-1:0]    pollution_seen
);
    import ppft_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_RES
    } state_t;

    state_t            state_reg, state_next;
    logic              clearing_reg, clearing_next;
    logic [IDX_W-1:0]  clr_addr_reg, clr_addr_next;
    logic [ECNT_W-1:0] ecnt_reg, ecnt_next;
    logic              epoch_reg, epoch_next;
    logic [POL_W-1:0]  live_reg [CORES];
    logic [POL_W-1:0]  live_next [CORES];
    logic [POL_W-1:0]  snap_reg [CORES];
    logic [POL_W-1:0]  snap_next [CORES];
    cfg_t              cfg_reg, cfg_next;
    logic              done_reg, done_next;
    logic              epoch_end_reg, epoch_end_next;
    logic              dvalid_reg, dvalid_next;
    logic [1:0]        level_reg, level_next;
    logic [POL_W-1:0]  pseen_reg, pseen_next;

    cmd_t              cmd_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [CORE_W-1:0] core_reg;
    logic [NODE_W-1:0] node_reg;
    logic [DATA_W-1:0] useful_reg;
    logic [DATA_W-1:0] issued_reg;
    logic [DATA_W-1:0] bwc_reg;
    logic [DATA_W-1:0] bwno_reg;

    logic              accept;
    row_t              rd_row;
    row_t              wr_row;
    row_t              mod_row;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [POL_W-1:0]  pol;
    logic [1:0]        dec_level;

    assign busy      = clearing_reg || (state_reg == ST_READ);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    ppft_filter_ram u_ram
    (
        .clk   (clk),
        .ren   (accept),
        .raddr (filt_index(address)),
        .rdata (rd_row),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (wr_row)
    );

    ppft_decide u_decide
    (
        .clk    (clk),
        .load   (state_reg == ST_READ),
        .useful (useful_reg),
        .issued (issued_reg),
        .pol    (pol),
        .bwc    (bwc_reg),
        .bwno   (bwno_reg),
        .cfg    (cfg_reg),
        .level  (dec_level)
    );

    // capture the request
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= cmd_t'(command);
            idx_reg    <= filt_index(address);
            core_reg   <= core;
            node_reg   <= node_id;
            useful_reg <= useful_count;
            issued_reg <= issued_count;
            bwc_reg    <= bw_consumed;
            bwno_reg   <= bw_needed_others;
        end
    end

    // snapshot of the decided core, zero when the core does not exist
    always_comb
    begin
        pol = '0;
        for (int c = 0; c < CORES; c++)
        begin
            if (core_reg == CORE_W'(c))
                pol = snap_reg[c];
        end
    end

    // row update for clear and set
    always_comb
    begin
        mod_row = rd_row;
        for (int c = 0; c < CORES; c++)
        begin
            if (cmd_reg == CMD_CLEAR)
            begin
                if (rd_row[c].valid && (rd_row[c].owner == node_reg))
                    mod_row[c].mark = 1'b0;
            end
            else if (cmd_reg == CMD_SET)
            begin
                if (core_reg == CORE_W'(c))
                begin
                    mod_row[c].valid = 1'b1;
                    mod_row[c].mark  = 1'b1;
                    mod_row[c].owner = node_reg;
                end
            end
        end
    end

    always_comb
    begin
        if (clearing_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            wr_row    = '0;
        end
        else
        begin
            mem_we    = (state_reg == ST_READ) &&
                        ((cmd_reg == CMD_CLEAR) || (cmd_reg == CMD_SET));
            mem_waddr = idx_reg;
            wr_row    = mod_row;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clearing_next  = clearing_reg;
        clr_addr_next  = clr_addr_reg;
        ecnt_next      = ecnt_reg;
        epoch_next     = epoch_reg;
        cfg_next       = cfg_reg;
        done_next      = 1'b0;
        epoch_end_next = epoch_end_reg;
        dvalid_next    = dvalid_reg;
        level_next     = level_reg;
        pseen_next     = pseen_reg;
        for (int c = 0; c < CORES; c++)
        begin
            live_next[c] = live_reg[c];
            snap_next[c] = snap_reg[c];
        end

        if (clearing_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == IDX_LAST)
                clearing_next = 1'b0;
        end

        if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_ACC_LIMIT:  cfg_next.acc_limit  = cfg_data[ACC_W-1:0];
                REG_POL_LIMIT:  cfg_next.pol_limit  = cfg_data[POL_W-1:0];
                REG_BWC_LIMIT:  cfg_next.bwc_limit  = cfg_data;
                REG_BWNO_LIMIT: cfg_next.bwno_limit = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_READ;
            end
            ST_READ:
            begin
                state_next = ST_RES;
                epoch_next = 1'b0;
                if (cmd_reg == CMD_MISS)
                begin
                    for (int c = 0; c < CORES; c++)
                    begin
                        if (rd_row[c].valid && rd_row[c].mark &&
                            (rd_row[c].owner == node_reg) && (live_reg[c] != POL_MAX))
                            live_next[c] = live_reg[c] + 1'b1;
                    end
                    if (ecnt_reg == EPOCH_LAST)
                    begin
                        ecnt_next  = '0;
                        epoch_next = 1'b1;
                        for (int c = 0; c < CORES; c++)
                        begin
                            snap_next[c] = live_next[c];
                            live_next[c] = '0;
                        end
                    end
                    else
                        ecnt_next = ecnt_reg + 1'b1;
                end
            end
            ST_RES:
            begin
                done_next      = 1'b1;
                epoch_end_next = epoch_reg;
                dvalid_next    = (cmd_reg == CMD_DECIDE);
                level_next     = (cmd_reg == CMD_DECIDE) ? dec_level : LVL_LOW;
                pseen_next     = (cmd_reg == CMD_DECIDE) ? pol : '0;
                state_next     = accept ? ST_READ : ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            clearing_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            ecnt_reg      <= '0;
            epoch_reg     <= 1'b0;
            cfg_reg       <= '{acc_limit:  ACC_LIMIT_RST,
                               pol_limit:  POL_LIMIT_RST,
                               bwc_limit:  BWC_LIMIT_RST,
                               bwno_limit: BWNO_LIMIT_RST};
            done_reg      <= 1'b0;
            epoch_end_reg <= 1'b0;
            dvalid_reg    <= 1'b0;
            level_reg     <= '0;
            pseen_reg     <= '0;
            for (int c = 0; c < CORES; c++)
            begin
                live_reg[c] <= '0;
                snap_reg[c] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            clearing_reg  <= clearing_next;
            clr_addr_reg  <= clr_addr_next;
            ecnt_reg      <= ecnt_next;
            epoch_reg     <= epoch_next;
            cfg_reg       <= cfg_next;
            done_reg      <= done_next;
            epoch_end_reg <= epoch_end_next;
            dvalid_reg    <= dvalid_next;
            level_reg     <= level_next;
            pseen_reg     <= pseen_next;
            for (int c = 0; c < CORES; c++)
            begin
                live_reg[c] <= live_next[c];
                snap_reg[c] <= snap_next[c];
            end
        end
    end

    assign done           = done_reg;
    assign epoch_end      = epoch_end_reg;
    assign decision_valid = dvalid_reg;
    assign level          = level_reg;
    assign pollution_seen = pseen_reg;

endmodule

[hdl/ppft_filter_ram.sv]
module ppft_filter_ram
(
    input  logic                     clk,
    input  logic                     ren,
    input  logic [ppft_pkg::IDX_W-1:0] raddr,
    output ppft_pkg::row_t           rdata,
    input  logic                     we,
    input  logic [ppft_pkg::IDX_W-1:0] waddr,
    input  ppft_pkg::row_t           wdata
);
    import ppft_pkg::*;

    row_t mem [FILTER_ENTRIES];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ren)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hdl/ppft_decide.sv]
module ppft_decide
(
    input  logic                        clk,
    input  logic                        load,
    input  logic [ppft_pkg::DATA_W-1:0] useful,
    input  logic [ppft_pkg::DATA_W-1:0] issued,
    input  logic [ppft_pkg::POL_W-1:0]  pol,
    input  logic [ppft_pkg::DATA_W-1:0] bwc,
    input  logic [ppft_pkg::DATA_W-1:0] bwno,
    input  ppft_pkg::cfg_t              cfg,
    output logic [1:0]                  level
);
    import ppft_pkg::*;

    logic [PROD_W-1:0] prod_u_reg;
    logic [PROD_W-1:0] prod_l_reg;
    logic              low_acc;
    lvl_t              lvl;

    // products first, compare in the following cycle
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_u_reg <= PROD_W'(useful) * PROD_W'(1000);
            prod_l_reg <= PROD_W'(cfg.acc_limit) * PROD_W'(issued);
        end
    end

    always_comb
    begin
        low_acc = prod_u_reg < prod_l_reg;
        if (low_acc)
        begin
            if (bwno > cfg.bwno_limit)
                lvl = LVL_HIGH;
            else if (pol > cfg.pol_limit)
                lvl = LVL_HIGH;
            else if (bwc < cfg.bwc_limit)
                lvl = LVL_MID;
            else
                lvl = LVL_LOW;
        end
        else if (pol < cfg.pol_limit)
            lvl = LVL_LOW;
        else if (bwc < cfg.bwc_limit)
            lvl = (bwno < cfg.bwno_limit) ? LVL_LOW : LVL_MID;
        else
            lvl = (bwno < cfg.bwno_limit) ? LVL_MID : LVL_HIGH;
    end

    assign level = lvl;

endmodule

[hdl/ppft_checker.sv]
module ppft_checker
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       done,
    input logic                       epoch_end,
    input logic                       decision_valid,
    input logic [1:0]                 level,
    input logic [ppft_pkg::POL_W-1:0] pollution_seen
);
    import ppft_pkg::*;

    // a taken request raises busy right after it, blocking the next one
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy low right after a request was taken");

    a_done_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("results on consecutive cycles");

    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(decision_valid && epoch_end))
        else $error("decision and epoch end on the same result");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done && decision_valid) |-> (level <= LVL_HIGH))
        else $error("level out of range");

    a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !decision_valid) |-> ((level == LVL_LOW) && (pollution_seen == '0)))
        else $error("decision fields set on a non-decide result");

endmodule

bind prefetch_pollution_filter_throttle ppft_checker u_ppft_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .done           (done),
    .epoch_end      (epoch_end),
    .decision_valid (decision_valid),
    .level          (level),
    .pollution_seen (pollution_seen)
);
